// File: rtl/bbr_pkg.sv
// Shared types and constants for the 3x3 box blur with border renormalization.
// Holds configuration codes, reset values, reciprocal constants and the job record.
// No dependencies.
`timescale 1ns / 1ps

package bbr_pkg;

    // Default module parameters.
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_CHANNEL_BITS = 16;

    // Pixel layout: four channels, each carried in 16 port bits.
    localparam int NUM_CH       = 4;
    localparam int PORT_CH_BITS = 16;
    localparam int PORT_PIX_W   = NUM_CH * PORT_CH_BITS;

    // Window geometry.
    localparam int WIN_COLS = 3;
    localparam int WIN_ROWS = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_index;

    localparam logic [IMG_W_BITS-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [IMG_H_BITS-1:0] RESET_HEIGHT = 16'd480;

    // Division by the window count as a multiply by ceil(2^23 / count).
    // Exact for every dividend below 2^20, which covers 16-bit channels.
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_W     = 22;
    localparam logic [RECIP_W-1:0] RECIP_9 = 22'd932068;
    localparam logic [RECIP_W-1:0] RECIP_6 = 22'd1398102;
    localparam logic [RECIP_W-1:0] RECIP_4 = 22'd2097152;

    // One mean to compute: which border row and column take part, and its flags.
    typedef struct packed {
        logic use_row0;
        logic use_col0;
        logic eof;
        logic last;
    } t_job;

endpackage

// File: rtl/bbr_line_store.sv
// Two line stores for the box blur: the row above and the row two above.
// Synchronous memories with a registered read port.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module bbr_line_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_prev,
    output logic [DATA_W-1:0]        o_rd_prev2,
    input  logic                     i_wr_en,
    input  logic                     i_wr_prev2_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_prev,
    input  logic [DATA_W-1:0]        i_wr_prev2
);

    logic [DATA_W-1:0] mem_prev  [DEPTH];
    logic [DATA_W-1:0] mem_prev2 [DEPTH];

    // Row above: written with every pixel, read ahead of use.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_prev[i_wr_addr] <= i_wr_prev;
        end
        if (i_rd_en) begin
            o_rd_prev <= mem_prev[i_rd_addr];
        end
    end

    // Row two above: takes the old contents of the row above.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_prev2_en) begin
            mem_prev2[i_wr_addr] <= i_wr_prev2;
        end
        if (i_rd_en) begin
            o_rd_prev2 <= mem_prev2[i_rd_addr];
        end
    end

endmodule

// File: rtl/bbr_mean.sv
// Window mean unit: sums the selected pixels of the 3x3 window and divides by the count.
// Two registered stages (sum, reciprocal multiply) with a ready chain. Uses bbr_pkg.
`timescale 1ns / 1ps

module bbr_mean #(
    parameter int CHANNEL_BITS = bbr_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [bbr_pkg::NUM_CH*CHANNEL_BITS-1:0] i_win [bbr_pkg::WIN_COLS][bbr_pkg::WIN_ROWS],
    input  bbr_pkg::t_job                           i_job,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [bbr_pkg::NUM_CH*CHANNEL_BITS-1:0] o_data,
    output logic                                    o_eof,
    output logic                                    o_last
);

    localparam int NCH      = bbr_pkg::NUM_CH;
    localparam int PIX_W    = NCH * CHANNEL_BITS;
    localparam int COLSUM_W = CHANNEL_BITS + 2;
    localparam int SUM_W    = CHANNEL_BITS + 4;
    localparam int PROD_W   = SUM_W + bbr_pkg::RECIP_W;

    logic [COLSUM_W-1:0]         col_sum [NCH][bbr_pkg::WIN_COLS];
    logic [SUM_W-1:0]            win_sum [NCH];
    logic [2:0]                  half;
    logic [bbr_pkg::RECIP_W-1:0] recip;
    logic [PROD_W-1:0]           prod    [NCH];
    logic [PIX_W-1:0]            quot;

    logic             r_d_valid;
    logic [SUM_W-1:0] r_d_sum [NCH];
    logic             r_d_row0;
    logic             r_d_col0;
    logic             r_d_eof;
    logic             r_d_last;

    logic             r_e_valid;
    logic [PIX_W-1:0] r_e_data;
    logic             r_e_eof;
    logic             r_e_last;

    logic e_free;
    logic d_adv;

    // Ready chain through the two stages.
    assign e_free  = !r_e_valid || i_ready;
    assign d_adv   = r_d_valid && e_free;
    assign o_ready = !r_d_valid || d_adv;

    // Half the count, for rounding to nearest.
    always_comb begin
        case ({i_job.use_row0, i_job.use_col0})
            2'b11:        half = 3'd4;
            2'b10, 2'b01: half = 3'd3;
            default:      half = 3'd2;
        endcase
    end

    // Column sums first, then the window total with the rounding term.
    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            for (int col = 0; col < bbr_pkg::WIN_COLS; col++) begin
                col_sum[k][col] = '0;
                for (int row = 0; row < bbr_pkg::WIN_ROWS; row++) begin
                    if ((row != 0 || i_job.use_row0) && (col != 0 || i_job.use_col0)) begin
                        col_sum[k][col] = col_sum[k][col]
                            + COLSUM_W'(i_win[col][row][k*CHANNEL_BITS +: CHANNEL_BITS]);
                    end
                end
            end
            win_sum[k] = SUM_W'(col_sum[k][0]) + SUM_W'(col_sum[k][1])
                       + SUM_W'(col_sum[k][2]) + SUM_W'(half);
        end
    end

    // Reciprocal of the count: 9 in the interior, 6 on an edge, 4 in a corner.
    always_comb begin
        case ({r_d_row0, r_d_col0})
            2'b11:        recip = bbr_pkg::RECIP_9;
            2'b10, 2'b01: recip = bbr_pkg::RECIP_6;
            default:      recip = bbr_pkg::RECIP_4;
        endcase
    end

    // One multiplier per channel; the quotient is the high part of the product.
    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            prod[k] = PROD_W'(r_d_sum[k]) * PROD_W'(recip);
            quot[k*CHANNEL_BITS +: CHANNEL_BITS] = prod[k][bbr_pkg::RECIP_SHIFT +: CHANNEL_BITS];
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_d_valid <= i_valid;
            end
            if (e_free) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_d_sum  <= win_sum;
            r_d_row0 <= i_job.use_row0;
            r_d_col0 <= i_job.use_col0;
            r_d_eof  <= i_job.eof;
            r_d_last <= i_job.last;
        end
        if (d_adv) begin
            r_e_data <= quot;
            r_e_eof  <= r_d_eof;
            r_e_last <= r_d_last;
        end
    end

    assign o_valid = r_e_valid;
    assign o_data  = r_e_data;
    assign o_eof   = r_e_eof;
    assign o_last  = r_e_last;

endmodule

// File: rtl/box_blur_3x3_border_renorm.sv
// Top level of the streaming 3x3 box blur with border renormalization.
// Uses bbr_pkg, bbr_line_store (two line memories) and bbr_mean (sum and divide).
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata: red, green, blue, alpha
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: means, tlast: eof, tuser: last
//   cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One pixel per cycle unless stalled; the result issue stage produces one mean per cycle, so a
// pixel that completes several results holds the input until the last of them is issued.
// Results are registered through the read, window, sum and multiply stages, one line behind.
// Reset is synchronous and clears the position counters and pipeline flags; the line
// stores need no clearing pass. A stalled output backs up through the stages to s_axis.
`timescale 1ns / 1ps

module box_blur_3x3_border_renorm #(
    parameter int MAX_WIDTH    = bbr_pkg::DEF_MAX_WIDTH,
    parameter int CHANNEL_BITS = bbr_pkg::DEF_CHANNEL_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Fields from bit 0: in_red[15:0], in_green[31:16], in_blue[47:32], in_alpha[63:48].
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bbr_pkg::PORT_PIX_W-1:0]   s_axis_tdata,
    // Fields from bit 0: out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48].
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bbr_pkg::PORT_PIX_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast,
    // Fields from bit 0: last_of_run[0].
    output logic [0:0]                       m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bbr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int NCH   = bbr_pkg::NUM_CH;
    localparam int PIX_W = NCH * CHANNEL_BITS;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int HB    = bbr_pkg::IMG_H_BITS;

    // Results caused by one pixel, in the order they leave.
    typedef enum logic [3:0] {
        SEL_UP_LEFT  = 4'b0001,
        SEL_UP_LAST  = 4'b0010,
        SEL_CUR_LEFT = 4'b0100,
        SEL_CUR_LAST = 4'b1000
    } t_sel;

    logic [bbr_pkg::IMG_W_BITS-1:0] r_cfg_width;
    logic [HB-1:0]                  r_cfg_height;
    logic [COL_W-1:0]               r_col;
    logic [HB-1:0]                  r_row;

    logic [COL_W-1:0] w_last;
    logic [HB-1:0]    h_last;
    logic [COL_W-1:0] cur_col;
    logic [HB-1:0]    cur_row;
    logic             col_last;
    logic             row_last;
    logic [3:0]       sel_mask;
    logic [PIX_W-1:0] in_pix;
    logic             in_acc;

    logic             r_b_valid;
    logic [PIX_W-1:0] r_b_cur;
    logic [COL_W-1:0] r_b_col;
    logic [3:0]       r_b_mask;
    logic             r_b_row0;
    logic             r_b_col0;
    logic             r_b_wr2;
    logic [PIX_W-1:0] rd_prev;
    logic [PIX_W-1:0] rd_prev2;
    logic             b_adv;

    logic [PIX_W-1:0] r_win [bbr_pkg::WIN_COLS][bbr_pkg::WIN_ROWS];
    logic [3:0]       r_c_mask;
    logic             r_c_row0;
    logic             r_c_col0;
    logic [3:0]       sel_one;
    logic [3:0]       sel_rest;
    bbr_pkg::t_job    job;
    logic             mean_ready;
    logic             issue;
    logic             c_free;

    logic [PIX_W-1:0] mean_data;

    // Configuration writes; the port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= bbr_pkg::RESET_WIDTH;
            r_cfg_height <= bbr_pkg::RESET_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bbr_pkg::CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[bbr_pkg::IMG_W_BITS-1:0];
                bbr_pkg::CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[HB-1:0];
                default: ;
            endcase
        end
    end

    // Last column and row after clamping the frame size to its legal range.
    always_comb begin
        if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else if (r_cfg_width < 11'd2) begin
            w_last = COL_W'(1);
        end else begin
            w_last = COL_W'(r_cfg_width - 11'd1);
        end
        if (r_cfg_height < 16'd2) begin
            h_last = 16'd1;
        end else begin
            h_last = r_cfg_height - 16'd1;
        end
    end

    // Position of the incoming pixel; counters past the frame count as its edge.
    assign cur_col  = (r_col > w_last) ? w_last : r_col;
    assign cur_row  = (r_row > h_last) ? h_last : r_row;
    assign col_last = (cur_col == w_last);
    assign row_last = (cur_row == h_last);

    // Results this pixel completes.
    always_comb begin
        sel_mask = '0;
        if (cur_row != '0 && cur_col != '0) sel_mask = sel_mask | SEL_UP_LEFT;
        if (cur_row != '0 && col_last)      sel_mask = sel_mask | SEL_UP_LAST;
        if (row_last && cur_col != '0)      sel_mask = sel_mask | SEL_CUR_LEFT;
        if (row_last && col_last)           sel_mask = sel_mask | SEL_CUR_LAST;
    end

    // Only the low channel bits of each port field are kept.
    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            in_pix[k*CHANNEL_BITS +: CHANNEL_BITS] =
                s_axis_tdata[k*bbr_pkg::PORT_CH_BITS +: CHANNEL_BITS];
        end
    end

    assign s_axis_tready = !r_b_valid || b_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Position counters and the memory-read stage flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : cur_row + 16'd1;
                end else begin
                    r_col <= cur_col + COL_W'(1);
                    r_row <= cur_row;
                end
            end
            if (s_axis_tready) begin
                r_b_valid <= in_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_cur  <= in_pix;
            r_b_col  <= cur_col;
            r_b_mask <= sel_mask;
            r_b_row0 <= (cur_row > 16'd1);
            r_b_col0 <= (cur_col > COL_W'(1));
            r_b_wr2  <= (cur_row != '0);
        end
    end

    // Line stores: read at accept, written back when the pixel enters the window.
    bbr_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_line_store (
        .i_clk         (i_clk),
        .i_rd_en       (in_acc),
        .i_rd_addr     (cur_col),
        .o_rd_prev     (rd_prev),
        .o_rd_prev2    (rd_prev2),
        .i_wr_en       (b_adv),
        .i_wr_prev2_en (r_b_wr2),
        .i_wr_addr     (r_b_col),
        .i_wr_prev     (r_b_cur),
        .i_wr_prev2    (rd_prev)
    );

    // The window shifts only once every result of the previous pixel is issued.
    assign b_adv = r_b_valid && c_free;

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2][0] <= rd_prev2;
            r_win[2][1] <= rd_prev;
            r_win[2][2] <= r_b_cur;
            r_c_row0 <= r_b_row0;
            r_c_col0 <= r_b_col0;
        end
    end

    // Result issue: one pending result per cycle while the mean unit is ready, lowest bit first.
    assign sel_one  = r_c_mask & (~r_c_mask + 4'd1);
    assign sel_rest = r_c_mask & ~sel_one;
    assign issue    = (r_c_mask != '0) && mean_ready;
    assign c_free   = (r_c_mask == '0) || (issue && sel_rest == '0);

    always_comb begin
        job      = '0;
        job.last = (sel_rest == '0);
        case (sel_one)
            SEL_UP_LEFT: begin
                job.use_row0 = r_c_row0;
                job.use_col0 = r_c_col0;
            end
            SEL_UP_LAST: begin
                job.use_row0 = r_c_row0;
            end
            SEL_CUR_LEFT: begin
                job.use_col0 = r_c_col0;
            end
            SEL_CUR_LAST: begin
                job.eof = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_mask <= '0;
        end else if (b_adv) begin
            r_c_mask <= r_b_mask;
        end else if (issue) begin
            r_c_mask <= sel_rest;
        end
    end

    bbr_mean #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_mask != '0),
        .o_ready (mean_ready),
        .i_win   (r_win),
        .i_job   (job),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (mean_data),
        .o_eof   (m_axis_tlast),
        .o_last  (m_axis_tuser[0])
    );

    // Channels widen to the 16-bit port fields.
    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            m_axis_tdata[k*bbr_pkg::PORT_CH_BITS +: bbr_pkg::PORT_CH_BITS] =
                bbr_pkg::PORT_CH_BITS'(mean_data[k*CHANNEL_BITS +: CHANNEL_BITS]);
        end
    end

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for box_blur_3x3_border_renorm: RGBA frames go in, 3x3 means come out.
// A behavioral predictor of the line stores and window checks every result transaction.
// Depends on bbr_pkg and the box_blur_3x3_border_renorm top level only.
`timescale 1ns / 1ps

module tb_top;
    import bbr_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int SETTLE_CYCLES = 12;    // a margin over the result latency
    localparam int HOLD_CYCLES   = 200;   // long receiver stall that backs up the block
    localparam int STALL_LIMIT   = 5000;  // cycles without any transaction before giving up
    localparam int RANDOM_TARGET = 110;   // pixels in the closing random phases

    // Index the block has no register for; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE = 2'd3;

    typedef struct packed {
        logic [63:0] means;  // red, green, blue, alpha from bit 0
        logic        eof;
        logic        last;
    } t_blur_result;

    typedef enum logic {ROW_CONFIG, ROW_PIXEL} t_row_kind;

    // One row of the directed table: a register write or a pixel, and optionally the
    // channel means typed in for every result that pixel causes.
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [63:0]           pix;
        logic                  pin;
        logic [63:0]           pinned;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PORT_PIX_W-1:0] s_axis_tdata  = '0;  // red, green, blue, alpha from bit 0
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PORT_PIX_W-1:0] m_axis_tdata;        // red, green, blue, alpha from bit 0
    logic                  m_axis_tlast;        // end_of_frame
    logic [0:0]            m_axis_tuser;        // last_of_run
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Predictor state.
    logic [IMG_W_BITS-1:0] cfg_width  = RESET_WIDTH;
    logic [IMG_H_BITS-1:0] cfg_height = RESET_HEIGHT;
    logic [63:0]           row_above  [0:MAX_W-1];
    logic [63:0]           row_above2 [0:MAX_W-1];
    logic [63:0]           win_cols   [0:8];
    logic [9:0]            col_pos = '0;
    logic [15:0]           row_pos = '0;

    t_blur_result pending_means [$];
    t_stim_row    stim_rows [$];
    string        chan_names [4] = '{"red", "green", "blue", "alpha"};
    int           mismatch_count = 0;
    int           random_pixels  = 0;
    int           quiet_cycles   = 0;
    bit           idle_on  = 1'b1;
    bit           hold_req = 1'b0;

    box_blur_3x3_border_renorm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] pack_pix(input logic [15:0] red, green, blue, alpha);
        return {alpha, blue, green, red};
    endfunction

    // Channels lean toward the extremes so that rounding and overflow corners show up.
    function automatic logic [15:0] rand_channel();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 3));
            3: return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_pixel();
        return pack_pix(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    endfunction

    // Rounded mean over the window rows rlo..2 and columns clo..2.
    function automatic logic [63:0] box_mean(input int rlo, input int clo);
        logic [31:0] sums [4];
        logic [31:0] cnt;
        logic [63:0] m;
        int          col, row, k;
        cnt = 32'((3 - rlo) * (3 - clo));
        for (k = 0; k < 4; k++) sums[k] = '0;
        for (col = clo; col <= 2; col++)
            for (row = rlo; row <= 2; row++)
                for (k = 0; k < 4; k++)
                    sums[k] += 32'(win_cols[col * 3 + row][16 * k +: 16]);
        for (k = 0; k < 4; k++) m[16 * k +: 16] = 16'((sums[k] + cnt / 2) / cnt);
        return m;
    endfunction

    // Advances the predictor by one accepted pixel and queues the results it causes.
    task automatic predict_blur(input logic [63:0] pix, input bit pin,
                                input logic [63:0] pinned);
        int unsigned  w, h, c, r;
        int           rlo, clo, k;
        logic [63:0]  above, above2;
        t_blur_result res [$];
        w = cfg_width;
        if (w < 2) w = 2;
        if (w > MAX_W) w = MAX_W;
        h = cfg_height;
        if (h < 2) h = 2;
        c = (col_pos < w - 1) ? col_pos : w - 1;
        r = (row_pos < h - 1) ? row_pos : h - 1;

        above  = '0;
        above2 = '0;
        if (r >= 1) begin
            above = row_above[c];
            if (r >= 2) above2 = row_above2[c];
            row_above2[c] = above;
        end
        row_above[c] = pix;

        for (k = 0; k < 6; k++) win_cols[k] = win_cols[k + 3];
        win_cols[6] = above2;
        win_cols[7] = above;
        win_cols[8] = pix;

        // Results of the row above, then of the current row when it is the last one.
        rlo = (r >= 2) ? 0 : 1;
        clo = (c >= 2) ? 0 : 1;
        if (r >= 1) begin
            if (c >= 1) res.push_back('{box_mean(rlo, clo), 1'b0, 1'b0});
            if (c == w - 1) res.push_back('{box_mean(rlo, 1), 1'b0, 1'b0});
        end
        if (r == h - 1) begin
            if (c >= 1) res.push_back('{box_mean(1, clo), 1'b0, 1'b0});
            if (c == w - 1) res.push_back('{box_mean(1, 1), 1'b1, 1'b0});
        end
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[i]) begin
            if (pin) res[i].means = pinned;
            pending_means.push_back(res[i]);
        end

        if (c == w - 1) begin
            col_pos = '0;
            row_pos = (r == h - 1) ? 16'd0 : 16'(r + 1);
        end else begin
            col_pos = 10'(c + 1);
            row_pos = 16'(r);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Register writes wait until the block has drained and settled.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) cfg_width = data[IMG_W_BITS-1:0];
        else if (idx == CFG_IMAGE_HEIGHT) cfg_height = data;
    endtask

    task automatic cfg_frame(input logic [CFG_DATA_W-1:0] wdat, input logic [CFG_DATA_W-1:0] hdat);
        cfg_write(CFG_IMAGE_WIDTH, wdat);
        cfg_write(CFG_IMAGE_HEIGHT, hdat);
    endtask

    // Offers one pixel, possibly after an idle burst, and predicts it once accepted.
    task automatic send_pixel(input logic [63:0] pix, input bit pin, input logic [63:0] pinned);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_blur(pix, pin, pinned);
    endtask

    task automatic send_run(input int n);
        for (int i = 0; i < n; i++) send_pixel(rand_pixel(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
        random_pixels += n;
    endtask

    // Receiver: random stalls, plus one long hold when the sender asks for it.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_blur_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_means.size() == 0) begin
                flag_mismatch("unexpected result", m_axis_tdata, '0);
            end else begin
                want = pending_means.pop_front();
                for (int k = 0; k < 4; k++)
                    if (m_axis_tdata[16 * k +: 16] !== want.means[16 * k +: 16])
                        flag_mismatch(chan_names[k], 64'(m_axis_tdata[16 * k +: 16]),
                                      64'(want.means[16 * k +: 16]));
                if (m_axis_tlast !== want.eof)
                    flag_mismatch("end_of_frame", 64'(m_axis_tlast), 64'(want.eof));
                if (m_axis_tuser[0] !== want.last)
                    flag_mismatch("last_of_run", 64'(m_axis_tuser[0]), 64'(want.last));
            end
        end
    end

    // Watchdog on cycles in which no transaction happens on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("** box_blur_3x3_border_renorm: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        // Directed table: 2x2 frames whose four corner means are known outright,
        // including round-half-up, then a 3x3 frame with interior, edge and corner pixels.
        stim_rows.push_back('{ROW_CONFIG, CFG_IMAGE_WIDTH, 16'd2, 64'd0, 1'b0, 64'd0});
        stim_rows.push_back('{ROW_CONFIG, CFG_IMAGE_HEIGHT, 16'd2, 64'd0, 1'b0, 64'd0});
        repeat (4) stim_rows.push_back('{ROW_PIXEL, '0, '0, {64{1'b1}}, 1'b1, {64{1'b1}}});
        repeat (4) stim_rows.push_back('{ROW_PIXEL, '0, '0, 64'd0, 1'b1, 64'd0});
        stim_rows.push_back('{ROW_PIXEL, '0, '0, pack_pix(16'd0, 16'd0, 16'd0, 16'hFFFF),
                              1'b1, 64'hFFFF_0001_0000_0001});
        stim_rows.push_back('{ROW_PIXEL, '0, '0, pack_pix(16'd0, 16'd0, 16'd0, 16'hFFFF),
                              1'b1, 64'hFFFF_0001_0000_0001});
        stim_rows.push_back('{ROW_PIXEL, '0, '0, pack_pix(16'd0, 16'd0, 16'd1, 16'hFFFF),
                              1'b1, 64'hFFFF_0001_0000_0001});
        stim_rows.push_back('{ROW_PIXEL, '0, '0, pack_pix(16'd2, 16'd1, 16'd1, 16'hFFFE),
                              1'b1, 64'hFFFF_0001_0000_0001});
        stim_rows.push_back('{ROW_CONFIG, CFG_IMAGE_WIDTH, 16'd3, 64'd0, 1'b0, 64'd0});
        stim_rows.push_back('{ROW_CONFIG, CFG_IMAGE_HEIGHT, 16'd3, 64'd0, 1'b0, 64'd0});
        for (int k = 0; k < 9; k++)
            stim_rows.push_back('{ROW_PIXEL, '0, '0,
                                  pack_pix(16'(k * 7000), 16'(65535 - k * 7000),
                                           (k % 2) ? 16'hFFFF : 16'h0000, 16'(k * k * 800)),
                                  1'b0, 64'd0});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CONFIG) begin
                s_axis_tvalid <= 1'b0;
                cfg_write(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_pixel(stim_rows[i].pix, stim_rows[i].pin, stim_rows[i].pinned);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Tallest height, then lowered between rows: the row past the end acts as the last.
        cfg_frame(16'd2, 16'hFFFF);
        send_run(12);
        cfg_write(CFG_IMAGE_HEIGHT, 16'd3);
        send_run(8);

        // Long receiver hold while pixels keep coming, so the input stalls.
        cfg_frame(16'd6, 16'd8);
        send_run(14);
        @(posedge i_clk);
        hold_req = 1'b1;
        send_run(34);

        // Sender pauses mid-frame until every pending result has come out.
        cfg_frame(16'd5, 16'd4);
        send_run(9);
        while (pending_means.size() != 0) @(posedge i_clk);
        send_run(11);

        // Sizes below the minimum, and a width with stray high bits that are masked off.
        cfg_frame(16'd0, 16'd0);
        send_run(8);
        cfg_frame(16'hF803, 16'd1);
        send_run(12);

        // A write to an index with no register leaves the 3x2 frame untouched.
        cfg_write(CFG_INDEX_SPARE, 16'h0004);
        send_run(6);

        // Random small frames; the last stretch runs without any idling.
        random_pixels = 0;
        while (random_pixels < RANDOM_TARGET) begin
            int w, h;
            w = $urandom_range(2, 12);
            h = $urandom_range(2, 6);
            idle_on = (random_pixels < RANDOM_TARGET - 60) && ($urandom_range(0, 3) != 0);
            cfg_frame({5'($urandom_range(0, 31)), 11'(w)}, 16'(h));
            send_run(w * h * $urandom_range(1, 3));
        end

        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** box_blur_3x3_border_renorm: PASSED **");
        else
            $display("** box_blur_3x3_border_renorm: FAILED **");
        $finish;
    end

endmodule
